FILE: src/assert_macros.svh
// Assertion macros shared by the RTL; they expect clk and rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Expression must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error(msg);

`endif

FILE: src/g2de_pkg.sv
// Package for the 2D Gaussian pixel evaluator: types, stage map, constants, exp2 table.
`timescale 1ns / 1ps

package g2de_pkg;

  // Default coordinate width
  localparam int COORD_BITS_DEF = 10;

  // Configuration register map
  typedef enum logic [1:0] {
    REG_CENTER_ROW = 2'd0,
    REG_CENTER_COL = 2'd1,
    REG_INV_SIGMA_ROW = 2'd2,
    REG_INV_SIGMA_COL = 2'd3
  } cfg_reg_t;

  localparam int CENTER_W = 19;
  localparam int INV_W = 16;
  localparam int CFG_DATA_W = 19;
  localparam int VALUE_W = 16;

  // Pipeline stage map
  localparam int ST_MAG = 0;  // |coord - center|
  localparam int ST_MUL = 1;  // times reciprocal sigma
  localparam int ST_RND = 2;  // round and clamp to Q.12
  localparam int ST_SQR = 3;  // square
  localparam int ST_SUM = 4;  // half sum of squares
  localparam int ST_LOG = 5;  // times log2(e)
  localparam int ST_LUT = 6;  // table lookup
  localparam int ST_INT = 7;  // interpolation
  localparam int ST_OUT = 8;  // integer power shift, saturate
  localparam int NUM_STAGES = 9;

  // Per-stage load enables from the flow control
  typedef struct packed {
    logic [NUM_STAGES-1:0] load;
  } pipe_ctrl_t;

  // Datapath widths
  localparam int Z_W = 16;
  localparam int SQ_W = 31;
  localparam int A_W = 23;
  localparam int P_W = 40;
  localparam int B_W = 24;
  localparam int N_W = 8;
  localparam int M_W = 17;
  localparam int DIFF_W = 12;
  localparam int FRAC_W = 12;

  localparam logic [Z_W-1:0] Z_CLAMP = 16'h8000;     // 8.0 in Q.12
  localparam logic [16:0] LOG2E_Q16 = 17'd94548;
  localparam logic [N_W-1:0] N_ZERO_LIMIT = 8'd17;

  // 2^(-k/16) in Q.16, k = 0..16
  localparam logic [16:0] EXP2_TAB [17] = '{
    17'd65536, 17'd62757, 17'd60097, 17'd57549, 17'd55109, 17'd52773,
    17'd50535, 17'd48393, 17'd46341, 17'd44376, 17'd42495, 17'd40693,
    17'd38968, 17'd37316, 17'd35734, 17'd34219, 17'd32768
  };

endpackage

FILE: src/g2de_axis.sv
// One axis of the evaluator: distance, scale by reciprocal sigma, round, square.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module g2de_axis #(
  parameter int COORD_BITS = g2de_pkg::COORD_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  g2de_pkg::pipe_ctrl_t          ctrl,
  input  logic [COORD_BITS-1:0]         coord,
  input  logic [g2de_pkg::CENTER_W-1:0] center,
  input  logic [g2de_pkg::INV_W-1:0]    inv_sigma,
  output logic [g2de_pkg::SQ_W-1:0]     sq
);

  localparam int CW = COORD_BITS + 8;
  localparam int DW = ((CW > 18) ? CW : 18) + 2;
  localparam int MW = DW - 1;
  localparam int TW = MW + g2de_pkg::INV_W;
  localparam int RW = TW + 1 - 8;

  logic signed [DW-1:0] diff;
  logic [MW-1:0] mag;
  logic [TW-1:0] scaled;
  logic [TW:0] rnd_sum;
  logic [RW-1:0] z_full;
  logic [g2de_pkg::Z_W-1:0] z_next;
  logic [g2de_pkg::Z_W-1:0] z;
  logic [2*g2de_pkg::Z_W-1:0] sq_full;

  // Signed distance in Q.8 and its magnitude
  always_comb begin
    diff = $signed({{(DW-CW){1'b0}}, coord, 8'h00})
         - $signed({{(DW-g2de_pkg::CENTER_W){center[g2de_pkg::CENTER_W-1]}}, center});
  end

  always_ff @(posedge clk) begin
    if (ctrl.load[g2de_pkg::ST_MAG]) begin
      mag <= diff[DW-1] ? MW'(-diff) : diff[MW-1:0];
    end
  end

  // Scale by reciprocal sigma, Q.20
  always_ff @(posedge clk) begin
    if (ctrl.load[g2de_pkg::ST_MUL]) begin
      scaled <= mag * inv_sigma;
    end
  end

  // Round to Q.12 and clamp at 8 sigma
  always_comb begin
    rnd_sum = {1'b0, scaled} + (TW+1)'(128);
    z_full = rnd_sum[TW:8];
    if (z_full > {{(RW-g2de_pkg::Z_W){1'b0}}, g2de_pkg::Z_CLAMP}) begin
      z_next = g2de_pkg::Z_CLAMP;
    end else begin
      z_next = z_full[g2de_pkg::Z_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load[g2de_pkg::ST_RND]) begin
      z <= z_next;
    end
  end

  // Square, Q.24
  assign sq_full = z * z;

  always_ff @(posedge clk) begin
    if (ctrl.load[g2de_pkg::ST_SQR]) begin
      sq <= sq_full[g2de_pkg::SQ_W-1:0];
    end
  end

  `ASSERT_ALWAYS(a_z_clamped, z <= g2de_pkg::Z_CLAMP, "scaled distance above the clamp")

endmodule

FILE: src/g2de_exp.sv
// Exponent stages: half sum, times log2(e), exp2 table with interpolation, shift.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module g2de_exp (
  input  logic                         clk,
  input  logic                         rst,
  input  g2de_pkg::pipe_ctrl_t         ctrl,
  input  logic [g2de_pkg::SQ_W-1:0]    sq_row,
  input  logic [g2de_pkg::SQ_W-1:0]    sq_col,
  output logic [g2de_pkg::VALUE_W-1:0] value
);

  logic [g2de_pkg::SQ_W:0] sq_sum;
  logic [g2de_pkg::SQ_W:0] sq_rnd;
  logic [g2de_pkg::A_W-1:0] a;
  logic [g2de_pkg::P_W-1:0] prod;
  logic [g2de_pkg::P_W:0] prod_rnd;
  logic [g2de_pkg::B_W-1:0] b;
  logic [4:0] k_lo;
  logic [4:0] k_hi;
  logic [16:0] tab_lo;
  logic [16:0] tab_hi;
  logic [16:0] tab_diff;
  logic [g2de_pkg::M_W-1:0] lut_lo;
  logic [g2de_pkg::DIFF_W-1:0] lut_diff;
  logic [g2de_pkg::FRAC_W-1:0] lut_frac;
  logic [g2de_pkg::N_W-1:0] lut_n;
  logic [2*g2de_pkg::DIFF_W-1:0] interp;
  logic [2*g2de_pkg::DIFF_W:0] interp_rnd;
  logic [g2de_pkg::M_W-1:0] mant;
  logic [g2de_pkg::N_W-1:0] mant_n;
  logic [17:0] shift_rnd;
  logic [17:0] shifted;
  logic [g2de_pkg::M_W-1:0] pow_val;
  logic [g2de_pkg::VALUE_W-1:0] value_next;
  logic out_load;
  logic n_far;

  // a = 0.5 * (sq_row + sq_col), Q.16 rounded
  always_comb begin
    sq_sum = {1'b0, sq_row} + {1'b0, sq_col};
    sq_rnd = sq_sum + (g2de_pkg::SQ_W+1)'(256);
  end

  always_ff @(posedge clk) begin
    if (ctrl.load[g2de_pkg::ST_SUM]) begin
      a <= sq_rnd[g2de_pkg::SQ_W:9];
    end
  end

  // Times log2(e)
  always_ff @(posedge clk) begin
    if (ctrl.load[g2de_pkg::ST_LOG]) begin
      prod <= a * g2de_pkg::LOG2E_Q16;
    end
  end

  // Split into integer power and fraction, read neighboring table entries
  always_comb begin
    prod_rnd = {1'b0, prod} + (g2de_pkg::P_W+1)'(32768);
    b = prod_rnd[g2de_pkg::P_W-1:16];
    k_lo = {1'b0, b[15:12]};
    k_hi = k_lo + 5'd1;
    tab_lo = g2de_pkg::EXP2_TAB[k_lo];
    tab_hi = g2de_pkg::EXP2_TAB[k_hi];
    tab_diff = tab_lo - tab_hi;
  end

  always_ff @(posedge clk) begin
    if (ctrl.load[g2de_pkg::ST_LUT]) begin
      lut_lo <= tab_lo;
      lut_diff <= tab_diff[g2de_pkg::DIFF_W-1:0];
      lut_frac <= b[11:0];
      lut_n <= b[g2de_pkg::B_W-1:16];
    end
  end

  // Linear interpolation between entries
  always_comb begin
    interp = lut_diff * lut_frac;
    interp_rnd = {1'b0, interp} + (2*g2de_pkg::DIFF_W+1)'(2048);
  end

  always_ff @(posedge clk) begin
    if (ctrl.load[g2de_pkg::ST_INT]) begin
      mant <= lut_lo - {4'h0, interp_rnd[2*g2de_pkg::DIFF_W:12]};
      mant_n <= lut_n;
    end
  end

  // Divide by 2^n with rounding, then saturate
  always_comb begin
    shift_rnd = {1'b0, mant} + (18'd1 << (mant_n - 8'd1));
    shifted = shift_rnd >> mant_n;
    if (mant_n == '0) begin
      pow_val = mant;
    end else if (mant_n >= g2de_pkg::N_ZERO_LIMIT) begin
      pow_val = '0;
    end else begin
      pow_val = shifted[g2de_pkg::M_W-1:0];
    end
    value_next = pow_val[16] ? 16'hFFFF : pow_val[15:0];
  end

  always_ff @(posedge clk) begin
    if (ctrl.load[g2de_pkg::ST_OUT]) begin
      value <= value_next;
    end
  end

  // Flags for the output checks
  assign out_load = ctrl.load[g2de_pkg::ST_OUT];
  assign n_far = mant_n >= g2de_pkg::N_ZERO_LIMIT;

  `ASSERT_NEXT(a_far_zero, out_load && n_far, value == '0, "power beyond range must give zero")
  `ASSERT_NEXT(a_half_bound, out_load && mant_n != '0, value <= 16'd32768, "power must halve value")

endmodule

FILE: src/gaussian_2d_pixel_eval.sv
// Top level of the 2D Gaussian pixel evaluator: configuration, flow control, datapath.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Evaluates the unit-height Gaussian exp(-0.5*(dr^2 + dc^2)) at one pixel (row, col) per
// transaction and returns it as unsigned Q0.16, saturated at 65535. One pixel is accepted
// every cycle while the output is not held back; each result passes through the nine
// register stages (distance, sigma multiply, round, square, half sum, log2(e) multiply,
// table read, interpolation, power shift), the first loaded at the accepting edge. Stages
// that hold no valid pixel accept new data even while the output waits, so bubbles close
// up under output backpressure. Write the centers and reciprocal sigmas only while no
// pixel is in flight.

module gaussian_2d_pixel_eval #(
  parameter int COORD_BITS = g2de_pkg::COORD_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [1:0]                      cfg_index,
  input  logic [g2de_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [COORD_BITS-1:0]           row,
  input  logic [COORD_BITS-1:0]           col,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [g2de_pkg::VALUE_W-1:0]    value
);

  localparam int NS = g2de_pkg::NUM_STAGES;

  logic [g2de_pkg::CENTER_W-1:0] center_row;
  logic [g2de_pkg::CENTER_W-1:0] center_col;
  logic [g2de_pkg::INV_W-1:0] inv_sigma_row;
  logic [g2de_pkg::INV_W-1:0] inv_sigma_col;
  logic [NS-1:0] vld;
  logic [NS-1:0] rdy;
  g2de_pkg::pipe_ctrl_t ctrl;
  logic [g2de_pkg::SQ_W-1:0] sq_row;
  logic [g2de_pkg::SQ_W-1:0] sq_col;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      center_row <= '0;
      center_col <= '0;
      inv_sigma_row <= 16'd4096;
      inv_sigma_col <= 16'd4096;
    end else if (cfg_we) begin
      unique case (cfg_index)
        g2de_pkg::REG_CENTER_ROW: center_row <= cfg_data;
        g2de_pkg::REG_CENTER_COL: center_col <= cfg_data;
        g2de_pkg::REG_INV_SIGMA_ROW: inv_sigma_row <= cfg_data[g2de_pkg::INV_W-1:0];
        g2de_pkg::REG_INV_SIGMA_COL: inv_sigma_col <= cfg_data[g2de_pkg::INV_W-1:0];
        default: ;
      endcase
    end
  end

  // Stage ready: a stage loads when empty or when its content moves on
  always_comb begin
    rdy[NS-1] = !vld[NS-1] || out_ready;
    for (int i = NS - 2; i >= 0; i--) begin
      rdy[i] = !vld[i] || rdy[i+1];
    end
    ctrl.load = rdy;
  end

  assign in_ready = rdy[0];
  assign out_valid = vld[NS-1];

  // Valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) begin
        vld[0] <= in_valid;
      end
      for (int i = 1; i < NS; i++) begin
        if (rdy[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  g2de_axis #(
    .COORD_BITS(COORD_BITS)
  ) u_axis_row (
    .clk(clk),
    .rst(rst),
    .ctrl(ctrl),
    .coord(row),
    .center(center_row),
    .inv_sigma(inv_sigma_row),
    .sq(sq_row)
  );

  g2de_axis #(
    .COORD_BITS(COORD_BITS)
  ) u_axis_col (
    .clk(clk),
    .rst(rst),
    .ctrl(ctrl),
    .coord(col),
    .center(center_col),
    .inv_sigma(inv_sigma_col),
    .sq(sq_col)
  );

  g2de_exp u_exp (
    .clk(clk),
    .rst(rst),
    .ctrl(ctrl),
    .sq_row(sq_row),
    .sq_col(sq_col),
    .value(value)
  );

  `ASSERT_NEXT(a_accept_enters, in_valid && in_ready, vld[0], "accepted pixel lost")
  `ASSERT_ALWAYS(a_empty_ready, (vld != '0) || in_ready, "empty pipeline must accept input")

endmodule

FILE: tb/gaussian_2d_pixel_eval_test.sv
// Self-checking testbench for the 2D Gaussian pixel evaluator.
`timescale 1ns / 1ps

module gaussian_2d_pixel_eval_test;

  localparam int COORD = 10;
  localparam int IDLE_LIMIT = 2000;  // cycles with no transaction on either side
  localparam int LONG_HOLD = 60;     // output stall well past the pipeline depth
  localparam int SETTLE = 12;        // nine register stages plus margin

  // 2^(-k/16) in Q.16
  localparam int unsigned POW2_FRAC [17] = '{
    65536, 62757, 60097, 57549, 55109, 52773, 50535, 48393,
    46341, 44376, 42495, 40693, 38968, 37316, 35734, 34219, 32768
  };

  typedef struct packed {
    logic [COORD-1:0] r;
    logic [COORD-1:0] c;
  } pixel_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = g2de_pkg::REG_CENTER_ROW;
  logic [g2de_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [COORD-1:0] row = '0;
  logic [COORD-1:0] col = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [g2de_pkg::VALUE_W-1:0] value;

  // Local copy of the register file
  logic signed [g2de_pkg::CENTER_W-1:0] ctr_row;
  logic signed [g2de_pkg::CENTER_W-1:0] ctr_col;
  logic [g2de_pkg::INV_W-1:0] isig_row;
  logic [g2de_pkg::INV_W-1:0] isig_col;

  pixel_t pixel_q[$];
  logic [g2de_pkg::VALUE_W-1:0] gauss_q[$];

  logic in_taken = 1'b0;
  bit quiet = 1'b0;
  int send_gap = 0;
  int hold_left = 0;
  int holds_asked = 0;
  int holds_done = 0;
  int idle_cycles = 0;
  int mismatches = 0;
  int pixels_sent = 0;
  int results_seen = 0;
  int sat_seen = 0;
  int zero_seen = 0;
  int settings_used = 0;

  gaussian_2d_pixel_eval #(
    .COORD_BITS(COORD)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .row(row),
    .col(col),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .value(value)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Squared, sigma-scaled distance along one axis, Q.24
  function automatic longint unsigned axis_sq(logic [COORD-1:0] coord,
                                               logic signed [g2de_pkg::CENTER_W-1:0] ctr,
                                               logic [g2de_pkg::INV_W-1:0] inv);
    longint d;
    longint unsigned t;
    longint unsigned z;
    d = longint'(coord) * 256 - longint'(ctr);
    if (d < 0) d = -d;
    t = longint'(d) * longint'(inv);
    z = (t + 128) >> 8;
    if (z > 32768) z = 32768;
    return z * z;
  endfunction

  // exp(-a) for a in Q.16, result Q0.16 saturated
  function automatic logic [g2de_pkg::VALUE_W-1:0] neg_exp(longint unsigned a);
    longint unsigned b;
    longint unsigned n;
    int unsigned f;
    int unsigned k;
    int unsigned frac;
    int unsigned lo;
    int unsigned hi;
    int unsigned m;
    int unsigned v;
    b = (a * 94548 + 32768) >> 16;
    n = b >> 16;
    f = int'(b & 64'hFFFF);
    k = f >> 12;
    frac = f & 32'hFFF;
    lo = POW2_FRAC[k];
    hi = POW2_FRAC[k + 1];
    m = lo - (((lo - hi) * frac + 2048) >> 12);
    if (n == 0) v = m;
    else if (n >= 17) v = 0;
    else v = (m + (32'd1 << (n - 1))) >> n;
    return (v > 65535) ? 16'hFFFF : v[15:0];
  endfunction

  function automatic logic [g2de_pkg::VALUE_W-1:0] gauss_q16(logic [COORD-1:0] r,
                                                              logic [COORD-1:0] c);
    longint unsigned sum;
    sum = axis_sq(r, ctr_row, isig_row) + axis_sq(c, ctr_col, isig_col);
    return neg_exp((sum + 256) >> 9);
  endfunction

  // Driver: one pixel transaction at a time, random gaps between them
  always @(negedge clk) begin
    pixel_t px;
    if (rst) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else if (!in_valid || in_taken) begin
      if (send_gap == 0 && !quiet && $urandom_range(0, 11) == 0)
        send_gap = $urandom_range(1, 10);
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (pixel_q.size() > 0) begin
        px = pixel_q.pop_front();
        row <= px.r;
        col <= px.c;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stall bursts plus long holds on request
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (holds_done < holds_asked) begin
      holds_done++;
      hold_left = LONG_HOLD - 1;
      out_ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 9) == 0) begin
      hold_left = $urandom_range(0, 9);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Monitor: predict on input transactions, check on output transactions
  always @(posedge clk) begin
    logic [g2de_pkg::VALUE_W-1:0] want;
    if (rst) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_valid && in_ready;
      if (in_valid && in_ready) begin
        gauss_q.push_back(gauss_q16(row, col));
        pixels_sent++;
      end
      if (out_valid && out_ready) begin
        results_seen++;
        if (value == 16'hFFFF) sat_seen++;
        if (value == 16'h0000) zero_seen++;
        if (gauss_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("[%0t] ERROR: result value=%0d with nothing expected", $realtime, value);
        end else begin
          want = gauss_q.pop_front();
          if (value !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("[%0t] ERROR: value expected %0d, got %0d", $realtime, want, value);
          end
        end
      end
    end
  end

  // Watchdog on stretches with no transaction at all
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles == IDLE_LIMIT) begin
      $display("[%0t] Timeout: no transaction for %0d cycles", $realtime, IDLE_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic write_reg(g2de_pkg::cfg_reg_t idx, logic [g2de_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      g2de_pkg::REG_CENTER_ROW: ctr_row = data;
      g2de_pkg::REG_CENTER_COL: ctr_col = data;
      g2de_pkg::REG_INV_SIGMA_ROW: isig_row = data[g2de_pkg::INV_W-1:0];
      g2de_pkg::REG_INV_SIGMA_COL: isig_col = data[g2de_pkg::INV_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic setup(logic [g2de_pkg::CFG_DATA_W-1:0] cr, logic [g2de_pkg::CFG_DATA_W-1:0] cc,
                       logic [g2de_pkg::CFG_DATA_W-1:0] ir, logic [g2de_pkg::CFG_DATA_W-1:0] ic);
    write_reg(g2de_pkg::REG_CENTER_ROW, cr);
    write_reg(g2de_pkg::REG_CENTER_COL, cc);
    write_reg(g2de_pkg::REG_INV_SIGMA_ROW, ir);
    write_reg(g2de_pkg::REG_INV_SIGMA_COL, ic);
    settings_used++;
  endtask

  // Random center, sigma from a quarter pixel to about 200 pixels, junk in upper data bits
  task automatic random_setup();
    int cr;
    int cc;
    logic [g2de_pkg::INV_W-1:0] ir;
    logic [g2de_pkg::INV_W-1:0] ic;
    cr = int'($urandom_range(0, 270000)) - 4000;
    cc = int'($urandom_range(0, 270000)) - 4000;
    ir = 16'(1048576 / $urandom_range(64, 51200));
    ic = 16'(1048576 / $urandom_range(64, 51200));
    setup(cr[g2de_pkg::CFG_DATA_W-1:0], cc[g2de_pkg::CFG_DATA_W-1:0],
          {3'($urandom_range(0, 7)), ir}, {3'($urandom_range(0, 7)), ic});
  endtask

  task automatic push_pixel(int r, int c);
    pixel_t px;
    px.r = r[COORD-1:0];
    px.c = c[COORD-1:0];
    pixel_q.push_back(px);
  endtask

  // Mostly within a few sigma of the center, sometimes anywhere
  function automatic int near_coord(logic signed [g2de_pkg::CENTER_W-1:0] ctr,
                                    logic [g2de_pkg::INV_W-1:0] inv);
    int cpix;
    int spread;
    int v;
    if ($urandom_range(0, 3) == 0) return $urandom_range(0, 1023);
    cpix = int'(ctr) / 256;
    spread = (inv == 0) ? 1023 : 4 * 4096 / int'(inv) + 1;
    v = cpix + int'($urandom_range(0, 2 * spread)) - spread;
    if (v < 0) v = 0;
    if (v > 1023) v = 1023;
    return v;
  endfunction

  task automatic push_random(int count);
    repeat (count) push_pixel(near_coord(ctr_row, isig_row), near_coord(ctr_col, isig_col));
  endtask

  // Wait for every queued pixel to be sent and every result to come back
  task automatic drain();
    while (pixel_q.size() != 0 || in_valid || gauss_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  initial begin
    ctr_row = '0;
    ctr_col = '0;
    isig_row = 16'd4096;
    isig_col = 16'd4096;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset settings: peak at the origin, corners far out
    push_pixel(0, 0);
    push_pixel(1, 0);
    push_pixel(0, 1);
    push_pixel(2, 3);
    push_pixel(1023, 1023);
    push_pixel(1023, 0);
    push_pixel(0, 1023);
    push_pixel(682, 341);
    drain();

    // Half-pixel row center, steepest row sigma, flat column at the most negative center
    setup(19'(100 * 256 + 128), 19'h40000, 19'd65535, 19'd0);
    push_pixel(100, 0);
    push_pixel(101, 1023);
    push_pixel(0, 512);
    push_pixel(1023, 341);
    push_pixel(100, 682);
    drain();

    // Largest row center with flat row; widest column sigma, upper data bits set
    setup(19'h3FFFF, 19'(512 * 256), 19'h70000, 19'h70001);
    push_pixel(0, 0);
    push_pixel(1023, 1023);
    push_pixel(341, 512);
    push_pixel(682, 513);
    push_pixel(512, 1);
    drain();

    // Both axes flat: saturated everywhere
    setup(19'd0, 19'd0, 19'd0, 19'd0);
    push_pixel(0, 1023);
    push_pixel(1023, 0);
    push_pixel(555, 170);
    drain();

    // Random settings; long output hold in one, sender pause in another
    for (int ph = 0; ph < 6; ph++) begin
      random_setup();
      if (ph == 5) quiet = 1'b1;
      if (ph == 3) begin
        push_random(55);
        drain();
        push_random(60);
      end else begin
        push_random(115);
        if (ph == 1) holds_asked++;
      end
      drain();
    end

    $display("Covered %0d pixels over %0d register settings: %0d saturated, %0d zero.",
             pixels_sent, settings_used + 1, sat_seen, zero_seen);
    $display("Included flat axes, extreme centers and sigmas, a long output hold and a pause.");
    if (mismatches == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
